// ----- hw/rtl/srmd_pkg.sv -----
// shared constants and controller/datapath interface types for the strip dictionary
package srmd_pkg;

  localparam int DEF_COLUMN_HEIGHT = 11;
  localparam int DEF_MAX_ENTRIES   = 256;

  localparam int TILE_W   = 8;
  localparam int INDEX_W  = 8;
  localparam int LENGTH_W = 4;
  localparam int COUNT_W  = 9;

  localparam logic [TILE_W-1:0] RUN_BIT = 8'h40;

  // commands from the controller to the datapath
  typedef struct packed {
    logic collect_tile;
    logic search_init;
    logic search_step;
    logic finish_hit;
    logic finish_miss;
  } srmd_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last_tile;
    logic can_issue;
    logic rd_pending;
    logic hit;
  } srmd_status_t;

endpackage

// ----- hw/rtl/strip_run_merge_dictionary_core.sv -----
// top level of the strip run-merge dictionary: controller plus datapath
// a column takes COLUMN_HEIGHT tile requests, one per cycle while busy is low
// busy rises after the last tile; the search reads entries in index order, stops at
// the first hit, on a miss reads them all; one ram read per cycle sets the search time
// the result strobe comes in the cycle busy falls; the receiver cannot stall it
// synchronous active-low reset clears the pending strip and the entry count
module strip_run_merge_dictionary_core
  import srmd_pkg::*;
#(
  parameter int COLUMN_HEIGHT = DEF_COLUMN_HEIGHT,
  parameter int MAX_ENTRIES   = DEF_MAX_ENTRIES
) (
  input  logic                clk,
  input  logic                rst_n,
  // tile request channel
  input  logic                start,
  output logic                busy,
  input  logic [TILE_W-1:0]   in_tile,
  // result channel, one-cycle strobe
  output logic                out_valid,
  output logic [INDEX_W-1:0]  out_strip_index,
  output logic                out_is_new,
  output logic                out_table_full,
  output logic [LENGTH_W-1:0] out_strip_length
);

  srmd_cmd_t    cmd;
  srmd_status_t status;

  // sequencing: collect tiles, then walk the dictionary
  srmd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  // compaction, ram, compare and result registers
  srmd_datapath #(
    .COLUMN_HEIGHT(COLUMN_HEIGHT),
    .MAX_ENTRIES  (MAX_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .tile      (in_tile),
    .status    (status),
    .res_valid (out_valid),
    .res_index (out_strip_index),
    .res_new   (out_is_new),
    .res_full  (out_table_full),
    .res_length(out_strip_length)
  );

endmodule

// ----- hw/rtl/srmd_ram.sv -----
// generic single write port ram with registered read
module srmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/srmd_ctrl.sv -----
// controller state machine: tile collection and dictionary search sequencing
module srmd_ctrl
  import srmd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  srmd_status_t status,
  output srmd_cmd_t    cmd,
  output logic         busy
);

  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_SEARCH  = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_COLLECT: begin
        cmd.collect_tile = start;
        if (start && status.last_tile) begin
          cmd.search_init = 1'b1;
          state_nxt       = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status.hit) begin
          cmd.finish_hit = 1'b1;
          state_nxt      = ST_COLLECT;
        end else if (!status.can_issue && !status.rd_pending) begin
          cmd.finish_miss = 1'b1;
          state_nxt       = ST_COLLECT;
        end else begin
          cmd.search_step = status.can_issue;
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_COLLECT);

endmodule

// ----- hw/rtl/srmd_datapath.sv -----
// datapath: pending strip compaction, dictionary ram, search compare and result registers
module srmd_datapath
  import srmd_pkg::*;
#(
  parameter int COLUMN_HEIGHT = DEF_COLUMN_HEIGHT,
  parameter int MAX_ENTRIES   = DEF_MAX_ENTRIES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  srmd_cmd_t           cmd,
  input  logic [TILE_W-1:0]   tile,
  output srmd_status_t        status,
  output logic                res_valid,
  output logic [INDEX_W-1:0]  res_index,
  output logic                res_new,
  output logic                res_full,
  output logic [LENGTH_W-1:0] res_length
);

  localparam int POS_W  = $clog2(COLUMN_HEIGHT);
  localparam int LEN_W  = $clog2(COLUMN_HEIGHT + 1);
  localparam int AW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int IW     = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
  localparam int WORD_W = COLUMN_HEIGHT * TILE_W + LEN_W;

  // pending strip
  logic [TILE_W-1:0] strip_r   [COLUMN_HEIGHT];
  logic [TILE_W-1:0] strip_nxt [COLUMN_HEIGHT];
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;

  // dictionary bookkeeping and search
  logic [COUNT_W-1:0] count_r;
  logic [IW-1:0]      idx_r;
  logic [IW-1:0]      rd_idx_r;
  logic               rd_valid_r;

  // result
  logic                out_valid_r;
  logic [INDEX_W-1:0]  out_index_r;
  logic                out_new_r;
  logic                out_full_r;
  logic [LENGTH_W-1:0] out_len_r;

  logic [POS_W-1:0]  last_idx;
  logic              run;
  logic [WORD_W-1:0] pend_word;
  logic [WORD_W-1:0] rd_word;
  logic [IW-1:0]     count_ext;
  logic [IW-1:0]     max_ext;
  logic              dict_full;
  logic              wr_en;

  assign last_idx  = POS_W'(len_r - 1'b1);
  assign run       = (len_r != '0) && (strip_r[last_idx] == tile);
  assign count_ext = IW'(count_r);
  assign max_ext   = IW'(MAX_ENTRIES);
  assign dict_full = (count_ext >= max_ext);
  assign wr_en     = cmd.finish_miss && !dict_full;

  always_comb begin
    pend_word = '0;
    for (int k = 0; k < COLUMN_HEIGHT; k++) begin
      pend_word[k*TILE_W +: TILE_W] = strip_r[k];
    end
    pend_word[WORD_W-1 -: LEN_W] = len_r;
  end

  // run merge or append; cleared when a result is finished
  always_comb begin
    len_nxt = len_r;
    pos_nxt = pos_r;
    for (int k = 0; k < COLUMN_HEIGHT; k++) begin
      strip_nxt[k] = strip_r[k];
    end
    if (cmd.finish_hit || cmd.finish_miss) begin
      for (int k = 0; k < COLUMN_HEIGHT; k++) begin
        strip_nxt[k] = '0;
      end
      len_nxt = '0;
      pos_nxt = '0;
    end else if (cmd.collect_tile) begin
      for (int k = 0; k < COLUMN_HEIGHT; k++) begin
        if (run && (POS_W'(k) == last_idx)) begin
          strip_nxt[k] = tile | RUN_BIT;
        end else if (!run && (POS_W'(k) == POS_W'(len_r))) begin
          strip_nxt[k] = tile;
        end
      end
      if (!run) begin
        len_nxt = len_r + 1'b1;
      end
      if (!status.last_tile) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < COLUMN_HEIGHT; k++) begin
        strip_r[k] <= '0;
      end
      len_r       <= '0;
      pos_r       <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      rd_idx_r    <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      for (int k = 0; k < COLUMN_HEIGHT; k++) begin
        strip_r[k] <= strip_nxt[k];
      end
      len_r      <= len_nxt;
      pos_r      <= pos_nxt;
      rd_valid_r <= cmd.search_step;
      if (cmd.search_init) begin
        idx_r <= '0;
      end else if (cmd.search_step) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.search_step) begin
        rd_idx_r <= idx_r;
      end
      if (wr_en) begin
        count_r <= count_r + 1'b1;
      end
      out_valid_r <= cmd.finish_hit || cmd.finish_miss;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.finish_hit) begin
      out_index_r <= rd_idx_r[INDEX_W-1:0];
      out_new_r   <= 1'b0;
      out_full_r  <= 1'b0;
      out_len_r   <= LENGTH_W'(len_r);
    end else if (cmd.finish_miss) begin
      out_index_r <= dict_full ? '0 : count_r[INDEX_W-1:0];
      out_new_r   <= !dict_full;
      out_full_r  <= dict_full;
      out_len_r   <= LENGTH_W'(len_r);
    end
  end

  srmd_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_ENTRIES),
    .AW   (AW)
  ) u_dict_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(AW'(count_r)),
    .wdata(pend_word),
    .raddr(idx_r[AW-1:0]),
    .rdata(rd_word)
  );

  assign status.last_tile  = (pos_r == POS_W'(COLUMN_HEIGHT - 1));
  assign status.can_issue  = (idx_r < count_ext) && (idx_r < max_ext);
  assign status.rd_pending = rd_valid_r;
  assign status.hit        = rd_valid_r && (rd_word == pend_word);

  assign res_valid  = out_valid_r;
  assign res_index  = out_index_r;
  assign res_new    = out_new_r;
  assign res_full   = out_full_r;
  assign res_length = out_len_r;

endmodule

// ----- hw/rtl/srmd_checker.sv -----
// port-level assertions for the strip dictionary, bound to the top level
module srmd_checker
  import srmd_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic [INDEX_W-1:0]  out_strip_index,
  input logic                out_is_new,
  input logic                out_table_full
);

  // a result is never both a new entry and a full-table miss
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_new && out_table_full))
    else $error("result flagged both new and full");

  // full-table result carries index zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> (out_strip_index == '0))
    else $error("full-table result with nonzero index");

  // two results never come back to back
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back results");

  // a result follows a search and the block is ready again
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy))
    else $error("result strobe not at end of search");

  // a search only begins on an accepted request
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

endmodule

bind strip_run_merge_dictionary_core srmd_checker u_srmd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_strip_index(out_strip_index),
  .out_is_new     (out_is_new),
  .out_table_full (out_table_full)
);

// ----- tb/strip_run_merge_dictionary_core_tb.sv -----
// self-checking testbench for the strip run-merge dictionary core
`timescale 1ns / 1ps

module strip_run_merge_dictionary_core_tb;
  import srmd_pkg::*;

  localparam int COLUMN_HEIGHT     = DEF_COLUMN_HEIGHT;
  localparam int MAX_ENTRIES       = DEF_MAX_ENTRIES;
  localparam int CYCLE_LIMIT       = 2_000_000;
  // a miss on a full table searches every entry plus a little overhead
  localparam int DRAIN_CYCLES      = MAX_ENTRIES + 16;
  localparam int POST_FULL_COLUMNS = 40;
  localparam int PRESSURE_COLUMN   = 60;
  localparam int PRINT_CAP         = 40;

  // one result as the block reports it
  typedef struct packed {
    logic [INDEX_W-1:0]  strip_index;
    logic                is_new;
    logic                table_full;
    logic [LENGTH_W-1:0] strip_length;
  } strip_result_t;

  // a column of tiles, tile 0 (top) in the low byte
  typedef logic [COLUMN_HEIGHT*TILE_W-1:0] column_t;

  // predicts the dictionary and checks each result against the oldest prediction
  class strip_dictionary_checker;
    bit [TILE_W-1:0] entry_bytes [MAX_ENTRIES][COLUMN_HEIGHT];
    int              entry_len   [MAX_ENTRIES];
    int              entry_count;
    bit [TILE_W-1:0] pend_bytes  [COLUMN_HEIGHT];
    int              pend_len;
    int              tile_pos;
    strip_result_t   awaited [$];
    int              errors;
    int              new_strips;
    int              hits;
    int              full_misses;
    int              columns;

    // fold one accepted tile request into the pending strip
    function void absorb_tile(logic [TILE_W-1:0] tile);
      strip_result_t res;
      int            k;
      int            j;
      bit            found;
      bit            same;
      // a tile equal to the last stored byte (as it stands) marks a run
      if (pend_len > 0 && pend_bytes[pend_len-1] == tile)
        pend_bytes[pend_len-1] = tile | RUN_BIT;
      else if (pend_len < COLUMN_HEIGHT) begin
        pend_bytes[pend_len] = tile;
        pend_len++;
      end
      tile_pos++;
      if (tile_pos < COLUMN_HEIGHT)
        return;

      res = '0;
      res.strip_length = LENGTH_W'(pend_len);
      found = 1'b0;
      // first match in index order wins
      for (k = 0; k < entry_count && !found; k++) begin
        same = (entry_len[k] == pend_len);
        for (j = 0; j < pend_len; j++)
          if (entry_bytes[k][j] != pend_bytes[j])
            same = 1'b0;
        if (same) begin
          found = 1'b1;
          res.strip_index = INDEX_W'(k);
        end
      end

      if (found) begin
        hits++;
      end else if (entry_count >= MAX_ENTRIES) begin
        // nothing stored, index reads zero
        res.table_full = 1'b1;
        full_misses++;
      end else begin
        for (j = 0; j < COLUMN_HEIGHT; j++)
          entry_bytes[entry_count][j] = pend_bytes[j];
        entry_len[entry_count] = pend_len;
        res.strip_index = INDEX_W'(entry_count);
        res.is_new = 1'b1;
        entry_count++;
        new_strips++;
      end
      awaited.push_back(res);
      columns++;

      for (j = 0; j < COLUMN_HEIGHT; j++)
        pend_bytes[j] = '0;
      pend_len = 0;
      tile_pos = 0;
    endfunction

    task flag_mismatch(string msg);
      if (errors < PRINT_CAP)
        $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task compare_result(strip_result_t got);
      strip_result_t want;
      if (awaited.size() == 0) begin
        flag_mismatch($sformatf("result with none awaited (index %0d length %0d)",
                                got.strip_index, got.strip_length));
        return;
      end
      want = awaited.pop_front();
      if (got.strip_index !== want.strip_index)
        flag_mismatch($sformatf("strip_index %0h, awaited %0h", got.strip_index,
                                want.strip_index));
      if (got.is_new !== want.is_new)
        flag_mismatch($sformatf("is_new %b, awaited %b", got.is_new, want.is_new));
      if (got.table_full !== want.table_full)
        flag_mismatch($sformatf("table_full %b, awaited %b", got.table_full,
                                want.table_full));
      if (got.strip_length !== want.strip_length)
        flag_mismatch($sformatf("strip_length %0d, awaited %0d", got.strip_length,
                                want.strip_length));
    endtask
  endclass

  bit                  clk;
  logic                rst_n   = 1'b0;
  logic                start   = 1'b0;
  logic [TILE_W-1:0]   in_tile = '0;
  logic                busy;
  logic                out_valid;
  logic [INDEX_W-1:0]  out_strip_index;
  logic                out_is_new;
  logic                out_table_full;
  logic [LENGTH_W-1:0] out_strip_length;

  strip_dictionary_checker sb = new;
  column_t                 sent_columns [$];
  int                      cycles = 0;

  strip_run_merge_dictionary_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_tile          (in_tile),
    .out_valid        (out_valid),
    .out_strip_index  (out_strip_index),
    .out_is_new       (out_is_new),
    .out_table_full   (out_table_full),
    .out_strip_length (out_strip_length)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycles,
               sb.awaited.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result strobe lasts one cycle and cannot be held off, so take it every edge
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.compare_result('{out_strip_index, out_is_new, out_table_full, out_strip_length});
  end

  // one tile request: stay idle through the gap, then hold start until busy is low at an edge
  task automatic send_tile(logic [TILE_W-1:0] tile, int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_tile <= tile;
    do
      @(posedge clk);
    while (busy);
    sb.absorb_tile(tile);
  endtask

  // a whole column, with random gaps unless this is a back-to-back stretch
  task automatic send_column(column_t col, bit no_idle);
    int k;
    for (k = 0; k < COLUMN_HEIGHT; k++)
      send_tile(col[k*TILE_W +: TILE_W], no_idle ? 0 : $urandom_range(0, 9));
    sent_columns.push_back(col);
  endtask

  // drop the request first so nothing is taken while waiting
  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (sb.awaited.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    column_t           col;
    logic [TILE_W-1:0] tile;
    logic [TILE_W-1:0] base;
    int                k;
    int                pick;
    int                run_pct;
    int                fresh_pct;
    int                post_full;
    int                random_cols;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: zero first tile, 0xff, a run that absorbs its own marked byte,
    // a marked tile after a plain one, 0x40 runs, then a column whose first
    // tile equals the last byte of the previous strip; its repeats fold in pairs to six bytes
    send_column({8'hBF, 8'h40, 8'h40, 8'h7F, 8'h80, 8'h05,
                 8'h45, 8'h05, 8'h05, 8'hFF, 8'h00}, 1'b0);
    send_column({COLUMN_HEIGHT{8'hBF}}, 1'b0);

    // random: mostly fresh strips until the table fills, repeats for hits,
    // and short run-heavy columns built around one base tile
    post_full   = 0;
    random_cols = 0;
    while (post_full < POST_FULL_COLUMNS) begin
      if (sb.entry_count >= MAX_ENTRIES)
        post_full++;
      fresh_pct = (sb.entry_count >= MAX_ENTRIES) ? 40 : 92;
      pick = $urandom_range(0, 99);
      if (pick < fresh_pct) begin
        // run_pct zero forces no runs, so strips are full length unless tiles repeat by chance
        run_pct = 15 * $urandom_range(0, 3);
        for (k = 0; k < COLUMN_HEIGHT; k++) begin
          tile = TILE_W'($urandom_range(0, 255));
          if (k > 0 && $urandom_range(0, 99) < run_pct)
            tile = col[(k-1)*TILE_W +: TILE_W];
          col[k*TILE_W +: TILE_W] = tile;
        end
      end else if (pick < fresh_pct + (100 - fresh_pct) / 2) begin
        col = sent_columns[$urandom_range(0, sent_columns.size() - 1)];
      end else begin
        base = TILE_W'($urandom_range(0, 255));
        for (k = 0; k < COLUMN_HEIGHT; k++) begin
          case ($urandom_range(0, 3))
            0:       tile = base;
            1:       tile = base | RUN_BIT;
            2:       tile = base & ~RUN_BIT;
            default: tile = ~base;
          endcase
          col[k*TILE_W +: TILE_W] = tile;
        end
      end
      send_column(col, $urandom_range(0, 3) == 0);
      random_cols++;
      // hold the sender off once until the block has answered everything
      if (random_cols == PRESSURE_COLUMN)
        wait_for_results();
    end

    @(negedge clk);
    start <= 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d columns (%0d tile requests) in %0d cycles", sb.columns,
             sb.columns * COLUMN_HEIGHT, cycles);
    $display("strips stored %0d, matched %0d, refused by the full table %0d",
             sb.new_strips, sb.hits, sb.full_misses);
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/srmd_pkg.sv
hw/rtl/srmd_ram.sv
hw/rtl/srmd_ctrl.sv
hw/rtl/srmd_datapath.sv
hw/rtl/strip_run_merge_dictionary_core.sv
hw/rtl/srmd_checker.sv
tb/strip_run_merge_dictionary_core_tb.sv
